// ===== hdl/rgb565_crop_box_downscale_macros.svh =====
// Assertion helpers for the crop and box downscale block.
// Both sample on i_clk and are off while i_rst_n is low.
`ifndef RGB565_CROP_BOX_DOWNSCALE_MACROS_SVH
`define RGB565_CROP_BOX_DOWNSCALE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define RCBD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define RCBD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/rcbd_pkg.sv =====
package rcbd_pkg;

    // Default geometry
    localparam int SRC_WIDTH_DEF  = 480;
    localparam int SRC_HEIGHT_DEF = 272;
    localparam int CROP_SIZE_DEF  = 240;
    localparam int BLOCK_SIZE_DEF = 5;

    // Configuration port
    localparam int CFG_DATA_W    = 8;
    localparam int CROP_LEFT_RST = 120;
    localparam int CROP_TOP_RST  = 16;

    typedef enum logic [0:0] {
        CFG_CROP_LEFT = 1'b0,
        CFG_CROP_TOP  = 1'b1
    } t_cfg_reg;

    // Per-pixel block position flags, front end to accumulator ring
    typedef struct packed {
        logic first;       // first pixel of a block: overwrite the sum
        logic last;        // last pixel of a block: block average is due
        logic rot;         // last column of a block: move to next block column
        logic frame_last;  // last block of the output frame
    } t_pix_ctl;

    // 5-bit channel to 8 bits: (x*527 + 23) >> 6
    function automatic logic [7:0] expand_5(input logic [4:0] x);
        logic [14:0] t;
        t = 15'(x) * 15'(527) + 15'(23);
        return t[13:6];
    endfunction

    // 6-bit channel to 8 bits: (x*259 + 33) >> 6
    function automatic logic [7:0] expand_6(input logic [5:0] x);
        logic [14:0] t;
        t = 15'(x) * 15'(259) + 15'(33);
        return t[13:6];
    endfunction

    // 8-bit channels back to RGB565
    function automatic logic [15:0] pack_565(input logic [7:0] r, input logic [7:0] g,
                                             input logic [7:0] b);
        return {r[7:3], g[7:2], b[7:3]};
    endfunction

endpackage

// ===== hdl/rcbd_cell.sv =====
// One block-column accumulator cell of the ring: R, G, B sums side by side
module rcbd_cell import rcbd_pkg::*; #(
    parameter int W = 39
) (
    input  logic         i_clk,
    input  logic         i_load,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);

    logic [W-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_q <= i_d;
        end
    end

    assign o_q = r_q;

endmodule

// ===== hdl/rcbd_front.sv =====
// Position tracking, window test and channel expansion; one registered stage
module rcbd_front import rcbd_pkg::*; #(
    parameter int SRC_WIDTH  = SRC_WIDTH_DEF,
    parameter int SRC_HEIGHT = SRC_HEIGHT_DEF,
    parameter int CROP_SIZE  = CROP_SIZE_DEF,
    parameter int BLOCK_SIZE = BLOCK_SIZE_DEF,
    localparam int COORD_W   = $clog2((SRC_WIDTH > SRC_HEIGHT) ? SRC_WIDTH : SRC_HEIGHT)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // source words
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [15:0]        i_pixel_in,
    input  logic               i_frame_start,
    // window corner, already limited to the frame
    input  logic [COORD_W-1:0] i_left,
    input  logic [COORD_W-1:0] i_top,
    // expanded pixel to the ring
    output logic               o_valid,
    input  logic               i_stall,
    output logic [7:0]         o_r8,
    output logic [7:0]         o_g8,
    output logic [7:0]         o_b8,
    output t_pix_ctl           o_ctl
);

    localparam int OUT_SIZE  = CROP_SIZE / BLOCK_SIZE;
    localparam int USED_SIZE = OUT_SIZE * BLOCK_SIZE;
    localparam int RX_W      = $clog2(BLOCK_SIZE);
    localparam int BX_W      = (OUT_SIZE > 1) ? $clog2(OUT_SIZE) : 1;

    logic [COORD_W-1:0] r_col, n_col, r_row, n_row;
    logic [RX_W-1:0]    r_rx, n_rx, r_ry, n_ry;
    logic [BX_W-1:0]    r_bx, n_bx, r_by, n_by;
    logic               r_v, n_v;
    logic [7:0]         r_r8, r_g8, r_b8;
    t_pix_ctl           r_ctl;

    logic [COORD_W-1:0] col, row;
    logic [COORD_W:0]   col_p1, row_p1;
    logic [RX_W-1:0]    cur_rx, cur_ry;
    logic [BX_W-1:0]    cur_bx, cur_by;
    logic               in_x, in_y, rx_end, ry_end, bx_end, by_end;
    logic               en, accept;
    t_pix_ctl           ctl;

    // current position and its place in the window
    always_comb begin
        col    = i_frame_start ? '0 : r_col;
        row    = i_frame_start ? '0 : r_row;
        in_x   = (col >= i_left) &&
                 ({1'b0, col} < ({1'b0, i_left} + (COORD_W+1)'(USED_SIZE)));
        in_y   = (row >= i_top) &&
                 ({1'b0, row} < ({1'b0, i_top} + (COORD_W+1)'(USED_SIZE)));
        cur_rx = (col == i_left) ? '0 : r_rx;
        cur_bx = (col == i_left) ? '0 : r_bx;
        cur_ry = (row == i_top) ? '0 : r_ry;
        cur_by = (row == i_top) ? '0 : r_by;
        rx_end = (cur_rx == RX_W'(BLOCK_SIZE - 1));
        ry_end = (cur_ry == RX_W'(BLOCK_SIZE - 1));
        bx_end = (cur_bx == BX_W'(OUT_SIZE - 1));
        by_end = (cur_by == BX_W'(OUT_SIZE - 1));

        ctl.first      = (cur_rx == '0) && (cur_ry == '0);
        ctl.last       = rx_end && ry_end;
        ctl.rot        = rx_end;
        ctl.frame_last = rx_end && ry_end && bx_end && by_end;
    end

    // handshake: the stage takes a word when empty or draining
    assign en      = !r_v || !i_stall;
    assign accept  = i_valid && en;
    assign o_stall = !en;

    // raster and block counters
    always_comb begin
        n_col  = r_col;
        n_row  = r_row;
        n_rx   = r_rx;
        n_bx   = r_bx;
        n_ry   = r_ry;
        n_by   = r_by;
        col_p1 = {1'b0, col} + 1'b1;
        row_p1 = {1'b0, row} + 1'b1;
        if (accept) begin
            if (col_p1 >= (COORD_W+1)'(SRC_WIDTH)) begin
                n_col = '0;
                n_row = (row_p1 >= (COORD_W+1)'(SRC_HEIGHT)) ? '0 : row_p1[COORD_W-1:0];
            end else begin
                n_col = col_p1[COORD_W-1:0];
                n_row = row;
            end
            if (in_x) begin
                n_rx = rx_end ? '0 : cur_rx + 1'b1;
                n_bx = rx_end ? cur_bx + 1'b1 : cur_bx;
            end
            // block row counters move at the last used column of a used row
            if (in_x && in_y && rx_end && bx_end) begin
                n_ry = ry_end ? '0 : cur_ry + 1'b1;
                n_by = ry_end ? cur_by + 1'b1 : cur_by;
            end
        end
        n_v = en ? (accept && in_x && in_y) : r_v;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_rx  <= '0;
            r_bx  <= '0;
            r_ry  <= '0;
            r_by  <= '0;
            r_v   <= 1'b0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            r_rx  <= n_rx;
            r_bx  <= n_bx;
            r_ry  <= n_ry;
            r_by  <= n_by;
            r_v   <= n_v;
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_r8  <= expand_5(i_pixel_in[15:11]);
            r_g8  <= expand_6(i_pixel_in[10:5]);
            r_b8  <= expand_5(i_pixel_in[4:0]);
            r_ctl <= ctl;
        end
    end

    assign o_valid = r_v;
    assign o_r8    = r_r8;
    assign o_g8    = r_g8;
    assign o_b8    = r_b8;
    assign o_ctl   = r_ctl;

endmodule

// ===== hdl/rcbd_avg.sv =====
// Block average: multiply by reciprocal of the block area, then pack to RGB565
module rcbd_avg import rcbd_pkg::*; #(
    parameter int BLOCK_SIZE = BLOCK_SIZE_DEF,
    localparam int AREA      = BLOCK_SIZE * BLOCK_SIZE,
    localparam int SUM_W     = $clog2(AREA * 255 + 1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [3*SUM_W-1:0] i_sum,
    input  logic               i_frame_last,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [15:0]        o_pixel_out,
    output logic               o_frame_last
);

    // exact floor division for sums below 2**SUM_W
    localparam int DIV_L  = $clog2(AREA);
    localparam int DIV_K  = SUM_W + DIV_L;
    localparam int RECIP  = ((1 << DIV_K) + AREA - 1) / AREA;
    localparam int PROD_W = DIV_K + 8;

    logic              r_v3, r_vo;
    logic [PROD_W-1:0] r_pr, r_pg, r_pb;
    logic              r_fl3, r_flo;
    logic [15:0]       r_pix;
    logic              en3, en_o;

    assign en_o    = !r_vo || !i_stall;
    assign en3     = !r_v3 || en_o;
    assign o_stall = !en3;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (en3) begin
                r_v3 <= i_valid;
            end
            if (en_o) begin
                r_vo <= r_v3;
            end
        end
    end

    // reciprocal products
    always_ff @(posedge i_clk) begin
        if (i_valid && en3) begin
            r_pr  <= PROD_W'(i_sum[3*SUM_W-1 -: SUM_W]) * PROD_W'(RECIP);
            r_pg  <= PROD_W'(i_sum[2*SUM_W-1 -: SUM_W]) * PROD_W'(RECIP);
            r_pb  <= PROD_W'(i_sum[SUM_W-1:0]) * PROD_W'(RECIP);
            r_fl3 <= i_frame_last;
        end
    end

    // quotient is the top byte; pack into the output register
    always_ff @(posedge i_clk) begin
        if (r_v3 && en_o) begin
            r_pix <= pack_565(r_pr[PROD_W-1 -: 8], r_pg[PROD_W-1 -: 8], r_pb[PROD_W-1 -: 8]);
            r_flo <= r_fl3;
        end
    end

    assign o_valid      = r_vo;
    assign o_pixel_out  = r_pix;
    assign o_frame_last = r_flo;

endmodule

// ===== hdl/rgb565_crop_box_downscale.sv =====
// Crop a square window from an RGB565 raster and average it over BLOCK_SIZE blocks.
// Throughput: one source word per cycle until stalled results fill the stages behind it.
// A block's average passes the expand, block sum, reciprocal multiply and pack/output
// registers in that order once the edge that accepts its last source word has passed.
// Reset (synchronous, active low): counters, valid bits and crop corner to defaults;
// block sums are undefined until written and get no clearing pass.
`include "rgb565_crop_box_downscale_macros.svh"
module rgb565_crop_box_downscale import rcbd_pkg::*; #(
    parameter int SRC_WIDTH  = SRC_WIDTH_DEF,
    parameter int SRC_HEIGHT = SRC_HEIGHT_DEF,
    parameter int CROP_SIZE  = CROP_SIZE_DEF,
    parameter int BLOCK_SIZE = BLOCK_SIZE_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration writes
    input  logic                  i_cfg_we,
    input  logic [0:0]            i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // source words
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [15:0]           i_pixel_in,
    input  logic                  i_frame_start,
    // result words
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [15:0]           o_pixel_out,
    output logic                  o_frame_last
);

    localparam int COORD_W  = $clog2((SRC_WIDTH > SRC_HEIGHT) ? SRC_WIDTH : SRC_HEIGHT);
    localparam int OUT_SIZE = CROP_SIZE / BLOCK_SIZE;
    localparam int N_CELLS  = (OUT_SIZE > 0) ? OUT_SIZE : 1;
    localparam int AREA     = BLOCK_SIZE * BLOCK_SIZE;
    localparam int SUM_W    = $clog2(AREA * 255 + 1);
    localparam int SUM3_W   = 3 * SUM_W;
    localparam int MAX_LEFT = (SRC_WIDTH >= CROP_SIZE) ? SRC_WIDTH - CROP_SIZE : 0;
    localparam int MAX_TOP  = (SRC_HEIGHT >= CROP_SIZE) ? SRC_HEIGHT - CROP_SIZE : 0;
    localparam int LEFT_RST = (CROP_LEFT_RST > MAX_LEFT) ? MAX_LEFT : CROP_LEFT_RST;
    localparam int TOP_RST  = (CROP_TOP_RST > MAX_TOP) ? MAX_TOP : CROP_TOP_RST;

    logic [COORD_W-1:0] r_left, n_left, r_top, n_top;

    // crop corner, limited so that the window fits in the frame
    always_comb begin
        n_left = r_left;
        n_top  = r_top;
        if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_CROP_LEFT: begin
                    n_left = (32'(i_cfg_data) > 32'(MAX_LEFT)) ?
                             COORD_W'(MAX_LEFT) : COORD_W'(i_cfg_data);
                end
                CFG_CROP_TOP: begin
                    n_top = (32'(i_cfg_data[5:0]) > 32'(MAX_TOP)) ?
                            COORD_W'(MAX_TOP) : COORD_W'(i_cfg_data[5:0]);
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= COORD_W'(LEFT_RST);
            r_top  <= COORD_W'(TOP_RST);
        end else begin
            r_left <= n_left;
            r_top  <= n_top;
        end
    end

    // front end
    logic       f_valid, f_stall;
    logic [7:0] f_r8, f_g8, f_b8;
    t_pix_ctl   f_ctl;

    rcbd_front #(
        .SRC_WIDTH  (SRC_WIDTH),
        .SRC_HEIGHT (SRC_HEIGHT),
        .CROP_SIZE  (CROP_SIZE),
        .BLOCK_SIZE (BLOCK_SIZE)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_pixel_in    (i_pixel_in),
        .i_frame_start (i_frame_start),
        .i_left        (r_left),
        .i_top         (r_top),
        .o_valid       (f_valid),
        .i_stall       (f_stall),
        .o_r8          (f_r8),
        .o_g8          (f_g8),
        .o_b8          (f_b8),
        .o_ctl         (f_ctl)
    );

    // accumulator ring: cell 0 holds the current block column; at the last column
    // of a block the updated sum enters the tail and every cell moves one place
    logic [SUM3_W-1:0] cell_q [N_CELLS];
    logic [SUM3_W-1:0] new_sum;
    logic [SUM_W-1:0]  hr, hg, hb;
    logic              upd, a_stall, en2;
    logic              r_v2;
    logic [SUM3_W-1:0] r_s2_sum;
    logic              r_s2_fl;

    assign en2     = !r_v2 || !a_stall;
    assign upd     = f_valid && en2;
    assign f_stall = !en2;

    always_comb begin
        hr      = cell_q[0][SUM3_W-1 -: SUM_W];
        hg      = cell_q[0][2*SUM_W-1 -: SUM_W];
        hb      = cell_q[0][SUM_W-1:0];
        if (f_ctl.first) begin
            new_sum = {SUM_W'(f_r8), SUM_W'(f_g8), SUM_W'(f_b8)};
        end else begin
            new_sum = {hr + SUM_W'(f_r8), hg + SUM_W'(f_g8), hb + SUM_W'(f_b8)};
        end
    end

    for (genvar i = 0; i < N_CELLS; i++) begin : g_cell
        logic              load;
        logic [SUM3_W-1:0] d;
        if (i == N_CELLS - 1) begin : g_tail
            assign d    = new_sum;
            assign load = upd && (f_ctl.rot || (i == 0));
        end else begin : g_body
            assign d    = f_ctl.rot ? cell_q[i+1] : new_sum;
            assign load = upd && (f_ctl.rot || (i == 0));
        end
        rcbd_cell #(.W(SUM3_W)) u_cell (
            .i_clk  (i_clk),
            .i_load (load),
            .i_d    (d),
            .o_q    (cell_q[i])
        );
    end

    // completed block sum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (en2) begin
            r_v2 <= f_valid && f_ctl.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (upd && f_ctl.last) begin
            r_s2_sum <= new_sum;
            r_s2_fl  <= f_ctl.frame_last;
        end
    end

    // divide and pack
    rcbd_avg #(.BLOCK_SIZE(BLOCK_SIZE)) u_avg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (r_v2),
        .o_stall      (a_stall),
        .i_sum        (r_s2_sum),
        .i_frame_last (r_s2_fl),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_pixel_out  (o_pixel_out),
        .o_frame_last (o_frame_last)
    );

    // checks
    `RCBD_ASSERT_NEXT(a_block_done, upd && f_ctl.last, r_v2, "finished block not captured")
    `RCBD_ASSERT_NOW(a_last_rot, f_valid && f_ctl.last, f_ctl.rot && !f_ctl.first, "bad block flags")
    `RCBD_ASSERT_NOW(a_frame_last, f_valid && f_ctl.frame_last, f_ctl.last, "frame end off block end")

endmodule

// ===== tb/tb_rgb565_crop_box_downscale.sv =====
`timescale 1ns / 100ps

module tb_rgb565_crop_box_downscale;
    import rcbd_pkg::*;

    // Geometry at the block's defaults
    localparam int SRC_W    = SRC_WIDTH_DEF;
    localparam int SRC_H    = SRC_HEIGHT_DEF;
    localparam int BLK      = BLOCK_SIZE_DEF;
    localparam int OUT_BLKS = CROP_SIZE_DEF / BLOCK_SIZE_DEF;
    localparam int USED     = OUT_BLKS * BLK;

    // Channel expansion to 8 bits: (x * mul + bias) >> 6
    localparam int unsigned EXP5_MUL  = 527;
    localparam int unsigned EXP5_BIAS = 23;
    localparam int unsigned EXP6_MUL  = 259;
    localparam int unsigned EXP6_BIAS = 33;

    localparam int FLUSH_CYCLES  = 8;     // pipeline is 4 deep
    localparam int DRAIN_LIMIT   = 1000;
    localparam int MAX_REPORTS   = 10;
    localparam int TIMEOUT_NS    = 80_000_000;
    localparam int RANDOM_PHASES = 6;

    typedef struct packed {
        logic [15:0] pixel;
        logic        frame_end;
    } t_block_word;

    // DUT inputs, all known from time zero
    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [0:0]            i_cfg_index   = CFG_CROP_LEFT;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;
    logic                  i_valid       = 1'b0;
    logic [15:0]           i_pixel_in    = '0;
    logic                  i_frame_start = 1'b0;
    logic                  i_stall       = 1'b0;

    logic                  o_stall;
    logic                  o_valid;
    logic [15:0]           o_pixel_out;
    logic                  o_frame_last;

    rgb565_crop_box_downscale dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_pixel_in    (i_pixel_in),
        .i_frame_start (i_frame_start),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_pixel_out   (o_pixel_out),
        .o_frame_last  (o_frame_last)
    );

    always #5 i_clk = ~i_clk;

    // Mirror of the block: crop corner, raster position, per-column block sums
    logic [7:0]  crop_left_q = 8'(CROP_LEFT_RST);
    logic [5:0]  crop_top_q  = 6'(CROP_TOP_RST);
    int unsigned src_col = 0;
    int unsigned src_row = 0;
    int unsigned acc_r [OUT_BLKS];
    int unsigned acc_g [OUT_BLKS];
    int unsigned acc_b [OUT_BLKS];
    t_block_word block_avgs_q [$];

    int unsigned words_sent     = 0;
    int unsigned blocks_checked = 0;
    int unsigned frame_ends     = 0;
    int unsigned fail_count     = 0;

    // Sender burst state and receiver stall pattern
    int unsigned burst_left  = 0;
    bit          sender_gaps = 1'b1;
    logic [15:0] stall_seed  = '0;
    logic [3:0]  stall_phase = '0;

    function automatic int unsigned clamp_corner(input int unsigned corner,
                                                 input int unsigned extent);
        int unsigned max_corner;
        max_corner = (extent >= CROP_SIZE_DEF) ? extent - CROP_SIZE_DEF : 0;
        return (corner > max_corner) ? max_corner : corner;
    endfunction

    function automatic int unsigned expand_channel(input int unsigned v, input int unsigned mul,
                                                   input int unsigned bias);
        return (v * mul + bias) >> 6;
    endfunction

    // Block-aligned test patterns over window coordinates
    function automatic logic [15:0] directed_pixel(input int unsigned wx, input int unsigned wy);
        case (((wx / BLK) + (wy / BLK)) % 8)
            0: return 16'hFFFF;
            1: return 16'h0000;
            2: return 16'hF800;
            3: return 16'h07E0;
            4: return 16'h001F;
            5: return ((wx + wy) % 2) ? 16'hFFFF : 16'h0000;
            6: return (wx % 2) ? 16'h8410 : 16'h7BEF;
            default: return 16'($urandom);
        endcase
    endfunction

    // Advance the mirror by one accepted source word; queue a block average when due
    task automatic accumulate_pixel(input logic [15:0] pix, input logic start);
        int unsigned left, top, wx, wy, bx, by, r8, g8, b8;
        logic [7:0]  ra, ga, ba;
        t_block_word avg;
        if (start) begin
            src_col = 0;
            src_row = 0;
        end
        left = clamp_corner(crop_left_q, SRC_W);
        top  = clamp_corner(crop_top_q, SRC_H);
        if (src_col >= left && src_row >= top &&
            src_col - left < USED && src_row - top < USED) begin
            wx = src_col - left;
            wy = src_row - top;
            bx = wx / BLK;
            by = wy / BLK;
            r8 = expand_channel(pix[15:11], EXP5_MUL, EXP5_BIAS);
            g8 = expand_channel(pix[10:5], EXP6_MUL, EXP6_BIAS);
            b8 = expand_channel(pix[4:0], EXP5_MUL, EXP5_BIAS);
            // first word of a block overwrites the sums
            if (wx % BLK == 0 && wy % BLK == 0) begin
                acc_r[bx] = r8;
                acc_g[bx] = g8;
                acc_b[bx] = b8;
            end else begin
                acc_r[bx] += r8;
                acc_g[bx] += g8;
                acc_b[bx] += b8;
            end
            if (wx % BLK == BLK - 1 && wy % BLK == BLK - 1) begin
                ra = 8'(acc_r[bx] / (BLK * BLK));
                ga = 8'(acc_g[bx] / (BLK * BLK));
                ba = 8'(acc_b[bx] / (BLK * BLK));
                avg.pixel     = {ra[7:3], ga[7:2], ba[7:3]};
                avg.frame_end = (bx == OUT_BLKS - 1 && by == OUT_BLKS - 1);
                block_avgs_q.push_back(avg);
            end
        end
        // raster advance, wrapping at the end of the frame
        src_col++;
        if (src_col >= SRC_W) begin
            src_col = 0;
            src_row++;
            if (src_row >= SRC_H)
                src_row = 0;
        end
    endtask

    // One source word: optional gap at a burst boundary, then hold until accepted
    task automatic send_word(input logic [15:0] pix, input logic start);
        int unsigned gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            if (sender_gaps)
                gap = $urandom_range(0, 6);
        end
        burst_left--;
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_pixel_in    <= pix;
        i_frame_start <= start;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        accumulate_pixel(pix, start);
        words_sent++;
    endtask

    // A raster run from column 0, row 0; only the first word flags a frame start
    task automatic send_run(input int unsigned count, input bit directed);
        int unsigned col, row, left, top;
        logic [15:0] pix;
        left = clamp_corner(crop_left_q, SRC_W);
        top  = clamp_corner(crop_top_q, SRC_H);
        for (int unsigned n = 0; n < count; n++) begin
            col = n % SRC_W;
            row = (n / SRC_W) % SRC_H;
            if (directed && col >= left && row >= top)
                pix = directed_pixel(col - left, row - top);
            else
                pix = 16'($urandom);
            send_word(pix, n == 0);
        end
    endtask

    task automatic cfg_write(input t_cfg_reg idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            CFG_CROP_LEFT: crop_left_q = data;
            CFG_CROP_TOP:  crop_top_q  = data[5:0];
            default: begin
            end
        endcase
    endtask

    // Stop sending, wait for outstanding averages, then let the pipeline empty
    task automatic drain_results(input int unsigned limit);
        int unsigned waited;
        waited = 0;
        i_valid <= 1'b0;
        while (block_avgs_q.size() != 0 && waited < limit) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (FLUSH_CYCLES) @(posedge i_clk);
        if (block_avgs_q.size() != 0) begin
            $display("ERROR: %0d block averages never arrived", block_avgs_q.size());
            fail_count += block_avgs_q.size();
            block_avgs_q.delete();
        end
    endtask

    task automatic check_block(input logic [15:0] pix, input logic frame_end);
        t_block_word want;
        if (block_avgs_q.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
                $display("ERROR: unexpected block average %h frame_last %b", pix, frame_end);
        end else begin
            want = block_avgs_q.pop_front();
            blocks_checked++;
            if (want.frame_end)
                frame_ends++;
            if (want.pixel !== pix || want.frame_end !== frame_end) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("ERROR: block %0d expected %h/%b, got %h/%b", blocks_checked,
                             want.pixel, want.frame_end, pix, frame_end);
            end
        end
    endtask

    // Result monitor; the receiver stalls on a rotating 16-bit pattern
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            check_block(o_pixel_out, o_frame_last);
        stall_phase <= stall_phase + 4'd1;
        i_stall     <= stall_seed[stall_phase];
    end

    // Reset corner, directed block patterns, first block row only
    task automatic test_default_window();
        stall_seed  = 16'($urandom);
        sender_gaps = 1'b1;
        send_run((CROP_TOP_RST + BLK) * SRC_W, 1'b1);
        drain_results(DRAIN_LIMIT);
    endtask

    // Corner at the origin, back-to-back words, no stalls
    task automatic test_origin_window();
        cfg_write(CFG_CROP_LEFT, '0);
        cfg_write(CFG_CROP_TOP, '0);
        stall_seed  = '0;
        sender_gaps = 1'b0;
        send_run(2 * BLK * SRC_W, 1'b1);
        drain_results(DRAIN_LIMIT);
    endtask

    // Both registers past the frame edge, full frame, then overrun into the next
    task automatic test_clamped_full_frame();
        int unsigned top;
        cfg_write(CFG_CROP_LEFT, '1);
        cfg_write(CFG_CROP_TOP, '1);
        top = clamp_corner(crop_top_q, SRC_H);
        stall_seed  = 16'hFFF0;
        sender_gaps = 1'b1;
        send_run(SRC_W * SRC_H + (top + BLK) * SRC_W, 1'b0);
        drain_results(DRAIN_LIMIT);
    endtask

    // Random corners, sometimes an abandoned frame first, ragged run lengths
    task automatic test_random_windows();
        int unsigned top, rows;
        repeat (RANDOM_PHASES) begin
            cfg_write(CFG_CROP_LEFT, 8'($urandom));
            cfg_write(CFG_CROP_TOP, 8'($urandom));
            stall_seed  = ($urandom_range(0, 3) == 0) ? 16'h0000 : 16'($urandom);
            sender_gaps = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 1))
                send_run($urandom_range(1, 3 * SRC_W), 1'b0);
            top  = clamp_corner(crop_top_q, SRC_H);
            rows = top + BLK * $urandom_range(1, 2) + $urandom_range(0, 3);
            send_run(rows * SRC_W, $urandom_range(0, 1));
            drain_results(DRAIN_LIMIT);
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_default_window();
        test_origin_window();
        test_clamped_full_frame();
        test_random_windows();

        drain_results(DRAIN_LIMIT);
        $display("Sent %0d source words over default, origin, clamped and random windows;",
                 words_sent);
        $display("checked %0d block averages, %0d of them frame ends.",
                 blocks_checked, frame_ends);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Watchdog
    initial begin
        #(TIMEOUT_NS);
        $display("ERROR: timeout, %0d block averages still pending", block_avgs_q.size());
        $display("CHECK FAILED");
        $finish;
    end

endmodule
